@@ rtl/cbc_pkg.sv @@
// cbc_pkg: shared types, codes and address helpers for the cartridge bank controller
// no dependencies; used by cbc_ctrl, cbc_datapath and the top level through scoped names

package cbc_pkg;

  // cartridge ram geometry
  localparam int RAM_DEPTH = 32768;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int RAM_DW    = 8;

  // physical rom address bits kept after wrapping, and the width of the result field
  localparam int ROM_ADDR_BITS = 21;
  localparam int ROM_FIELD_W   = 21;

  // stream payload widths
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 32;

  // request kinds
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // register selects on the config port
  localparam logic REG_ROM_SIZE = 1'b0;
  localparam logic REG_RAM_SIZE = 1'b1;

  // ram size codes
  localparam logic [1:0] RAM_SZ_NONE = 2'd0;
  localparam logic [1:0] RAM_SZ_2K   = 2'd1;
  localparam logic [1:0] RAM_SZ_8K   = 2'd2;
  localparam logic [1:0] RAM_SZ_32K  = 2'd3;

  // bus address regions, addr[15:13]
  localparam logic [2:0] RGN_RAM_EN   = 3'd0;
  localparam logic [2:0] RGN_ROM_BANK = 3'd1;
  localparam logic [2:0] RGN_RAM_BANK = 3'd2;
  localparam logic [2:0] RGN_MODE     = 3'd3;
  localparam logic [2:0] RGN_CART_RAM = 3'd5;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;
  localparam logic [7:0] OPEN_BUS   = 8'hFF;

  typedef enum logic [1:0] {
    KIND_ROM   = 2'd0,
    KIND_RAM   = 2'd1,
    KIND_OPEN  = 2'd2,
    KIND_WDONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RAM_RD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_en;
    logic accept;
    logic load_direct;
    logic load_ram;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic ram_read;
  } status_t;

  // bank mask (2 << code) - 1, capped at 0x1f
  function automatic logic [4:0] bank_mask(input logic [2:0] code);
    logic [4:0] m;
    begin
      unique case (code)
        3'd0:    m = 5'h01;
        3'd1:    m = 5'h03;
        3'd2:    m = 5'h07;
        3'd3:    m = 5'h0F;
        default: m = 5'h1F;
      endcase
      return m;
    end
  endfunction

  // rom size mask, code 7 acts as code 6
  function automatic logic [ROM_FIELD_W-1:0] rom_size_mask(input logic [2:0] code);
    logic [2:0]  eff;
    logic [31:0] sz;
    logic [31:0] lim;
    begin
      eff = (code > 3'd6) ? 3'd6 : code;
      sz  = (32'd32768 << eff) - 32'd1;
      lim = (32'd1 << ROM_ADDR_BITS) - 32'd1;
      return ROM_FIELD_W'(sz & lim);
    end
  endfunction

endpackage

@@ rtl/cbc_ram.sv @@
// cbc_ram: generic single-port ram with registered read
// no dependencies

module cbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/cbc_ctrl.sv @@
// cbc_ctrl: sequencer for the ram clearing pass, request acceptance and result valid
// depends on cbc_pkg

module cbc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  cbc_pkg::status_t status,
  output cbc_pkg::cmd_t    cmd
);

  cbc_pkg::state_t state, state_next;
  logic            out_valid, out_valid_next;
  logic            ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cbc_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // the result register is free, or its transfer completes this cycle
  assign ready = !out_valid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      cbc_pkg::ST_CLEAR: begin
        if (status.clear_done) state_next = cbc_pkg::ST_IDLE;
      end
      cbc_pkg::ST_IDLE: begin
        if (s_tvalid && ready && status.ram_read) state_next = cbc_pkg::ST_RAM_RD;
      end
      cbc_pkg::ST_RAM_RD: begin
        state_next = cbc_pkg::ST_IDLE;
      end
      default: state_next = cbc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      cbc_pkg::ST_CLEAR: begin
        cmd.clear_en = 1'b1;
      end
      cbc_pkg::ST_IDLE: begin
        s_tready        = ready;
        cmd.accept      = s_tvalid && ready;
        cmd.load_direct = s_tvalid && ready && !status.ram_read;
      end
      cbc_pkg::ST_RAM_RD: begin
        cmd.load_ram = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.load_direct || cmd.load_ram) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign m_tvalid = out_valid;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == cbc_pkg::ST_CLEAR |-> !cmd.accept)
    else $error("request accepted during ram clear");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |-> !cmd.load_direct && !cmd.load_ram)
    else $error("pending result overwritten");

  a_rd_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == cbc_pkg::ST_RAM_RD |-> !out_valid)
    else $error("result register busy during ram read");

  a_rd_result: assert property (@(posedge clk) disable iff (rst)
    state == cbc_pkg::ST_RAM_RD |=> m_tvalid)
    else $error("ram read gave no result");

endmodule

@@ rtl/cbc_datapath.sv @@
// cbc_datapath: bank registers, rom/ram address mapping, cartridge ram, result register
// depends on cbc_pkg and cbc_ram

module cbc_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  cbc_pkg::cmd_t                 cmd,
  output cbc_pkg::status_t              status,
  input  logic [2:0]                    rom_size_code,
  input  logic [1:0]                    ram_size_code,
  input  logic                          req_type,
  input  logic [15:0]                   addr,
  input  logic [7:0]                    write_data,
  output cbc_pkg::kind_t                result_kind,
  output logic [cbc_pkg::ROM_FIELD_W-1:0] rom_addr,
  output logic [7:0]                    read_data
);

  logic [4:0] rom_bank_reg;
  logic [1:0] ram_bank_reg;
  logic       ram_enabled;
  logic       banking_mode;

  logic [cbc_pkg::RAM_AW-1:0] clr_cnt;

  logic [2:0]  region;
  logic        ram_hit;
  logic [14:0] idx_full;
  logic [cbc_pkg::RAM_AW-1:0] ram_idx;
  logic [6:0]  bank;
  logic [cbc_pkg::ROM_FIELD_W-1:0] rom_calc;

  cbc_pkg::kind_t                  d_kind;
  logic [cbc_pkg::ROM_FIELD_W-1:0] d_rom;
  logic [7:0]                      d_data;

  logic                       ram_we;
  logic [cbc_pkg::RAM_AW-1:0] ram_addr;
  logic [7:0]                 ram_wdata;
  logic [7:0]                 ram_rdata;

  assign region  = addr[15:13];
  assign ram_hit = ram_enabled && (ram_size_code != cbc_pkg::RAM_SZ_NONE);

  always_comb begin
    unique case (ram_size_code)
      cbc_pkg::RAM_SZ_2K:  idx_full = {4'b0, addr[10:0]};
      cbc_pkg::RAM_SZ_8K:  idx_full = {2'b0, addr[12:0]};
      cbc_pkg::RAM_SZ_32K: idx_full = banking_mode ? {ram_bank_reg, addr[12:0]}
                                                   : {2'b0, addr[12:0]};
      default:             idx_full = '0;
    endcase
  end

  assign ram_idx = idx_full[cbc_pkg::RAM_AW-1:0];

  // upper bank bits come from the ram bank register; low region only in mode 1
  always_comb begin
    if (!addr[14]) begin
      bank = banking_mode ? {ram_bank_reg, 5'b0} : 7'b0;
    end else begin
      bank = {ram_bank_reg, rom_bank_reg & cbc_pkg::bank_mask(rom_size_code)};
    end
  end

  assign rom_calc = {bank, addr[13:0]} & cbc_pkg::rom_size_mask(rom_size_code);

  always_comb begin
    d_kind = cbc_pkg::KIND_WDONE;
    d_rom  = '0;
    d_data = '0;
    if (req_type == cbc_pkg::REQ_READ) begin
      if (!addr[15]) begin
        d_kind = cbc_pkg::KIND_ROM;
        d_rom  = rom_calc;
      end else begin
        d_kind = cbc_pkg::KIND_OPEN;
        d_data = cbc_pkg::OPEN_BUS;
      end
    end
  end

  assign status.ram_read   = (req_type == cbc_pkg::REQ_READ) &&
                             (region == cbc_pkg::RGN_CART_RAM) && ram_hit;
  assign status.clear_done = &clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_reg <= '0;
      ram_bank_reg <= '0;
      ram_enabled  <= 1'b0;
      banking_mode <= 1'b0;
    end else if (cmd.accept && req_type == cbc_pkg::REQ_WRITE) begin
      unique case (region)
        cbc_pkg::RGN_RAM_EN:   ram_enabled  <= (write_data[3:0] == cbc_pkg::RAM_EN_KEY);
        cbc_pkg::RGN_ROM_BANK: rom_bank_reg <= (write_data[4:0] == 5'd0) ? 5'd1
                                                                         : write_data[4:0];
        cbc_pkg::RGN_RAM_BANK: ram_bank_reg <= write_data[1:0];
        cbc_pkg::RGN_MODE:     banking_mode <= write_data[0];
        default: ;
      endcase
    end
  end

  // clearing pass owns the port until it ends
  always_comb begin
    if (cmd.clear_en) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt;
      ram_wdata = '0;
    end else begin
      ram_we    = cmd.accept && (req_type == cbc_pkg::REQ_WRITE) &&
                  (region == cbc_pkg::RGN_CART_RAM) && ram_hit;
      ram_addr  = ram_idx;
      ram_wdata = write_data;
    end
  end

  cbc_ram #(
    .WIDTH (cbc_pkg::RAM_DW),
    .DEPTH (cbc_pkg::RAM_DEPTH)
  ) u_cart_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_direct) begin
      result_kind <= d_kind;
      rom_addr    <= d_rom;
      read_data   <= d_data;
    end else if (cmd.load_ram) begin
      result_kind <= cbc_pkg::KIND_RAM;
      rom_addr    <= '0;
      read_data   <= ram_rdata;
    end
  end

endmodule

@@ rtl/cartridge_bank_controller_core.sv @@
// cartridge_bank_controller_core: top level, config registers on the apb port
// depends on cbc_pkg, cbc_ctrl, cbc_datapath and cbc_ram
//
// usage:
//   one cpu bus access enters per transfer on the s_ side (s_tuser = read/write,
//   s_tdata = address and write byte); each access gives exactly one result on
//   the m_ side (m_tuser = result kind, m_tdata = rom address and read byte).
//   rom reads answer with the physical rom byte address, writes to the low 32 KiB
//   set the bank registers, accesses at 0xa000-0xbfff reach the internal ram.
// results:
//   rom reads, writes and open-bus reads: result valid in the cycle after the
//   transfer, one access per cycle while m_tready stays high. cartridge ram reads:
//   the byte passes the registered read port of the single-port ram and then the
//   result register, and no new access is taken until the result is loaded.
// reset:
//   bank registers and size codes clear; then a clearing pass zeroes all 32768
//   bytes of the ram, one byte a cycle, during which s_tready stays low. apb writes
//   are taken throughout.
// stall:
//   a result waits in the output register while m_tready is low; a new access
//   is taken only when that register is free or drains in the same cycle.

module cartridge_bank_controller_core (
  input  logic        clk,
  input  logic        rst,
  // apb config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [cbc_pkg::S_TDATA_W-1:0] s_tdata,  // addr[15:0], write_data[23:16]
  input  logic [0:0]  s_tuser,                    // req_type[0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [cbc_pkg::M_TDATA_W-1:0] m_tdata,  // rom_addr[20:0], read_data[28:21], zero
  output logic [1:0]  m_tuser                     // result_kind[1:0]
);

  logic [2:0] rom_size_code;
  logic [1:0] ram_size_code;

  cbc_pkg::cmd_t    cmd;
  cbc_pkg::status_t status;

  cbc_pkg::kind_t                  result_kind;
  logic [cbc_pkg::ROM_FIELD_W-1:0] rom_addr;
  logic [7:0]                      read_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_size_code <= '0;
      ram_size_code <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        cbc_pkg::REG_ROM_SIZE: rom_size_code <= pwdata[2:0];
        cbc_pkg::REG_RAM_SIZE: ram_size_code <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      cbc_pkg::REG_ROM_SIZE: prdata = {29'b0, rom_size_code};
      cbc_pkg::REG_RAM_SIZE: prdata = {30'b0, ram_size_code};
      default:               prdata = '0;
    endcase
  end

  cbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cbc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .rom_size_code (rom_size_code),
    .ram_size_code (ram_size_code),
    .req_type      (s_tuser[0]),
    .addr          (s_tdata[15:0]),
    .write_data    (s_tdata[23:16]),
    .result_kind   (result_kind),
    .rom_addr      (rom_addr),
    .read_data     (read_data)
  );

  assign m_tdata = {3'b0, read_data, rom_addr};
  assign m_tuser = result_kind;

endmodule
